/* hdl/dpq_pkg.sv */
// Shared types, constants and direction functions for the d-pad direction qualifier.
// No dependencies; every other file imports this package.
package dpq_pkg;

   localparam int DIR_W          = 4;
   localparam int TIME_W         = 32;
   localparam int DELAY_W        = 16;
   localparam int KEY_W          = 32;
   localparam int NUM_BUTTONS    = 4;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int SLOTS          = 3;
   localparam int QUEUE_DEPTH    = 4;
   localparam logic [DELAY_W-1:0] SETTLE_RESET = 16'd50;

   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE0  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE1  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE2  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE3  = 3'd4;

   localparam int SLOT_REL = 0;
   localparam int SLOT_PRS = 1;
   localparam int SLOT_REP = 2;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_PRESS   = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_REPEAT  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      EV_RELEASE = 2'd0,
      EV_PRESS   = 2'd1,
      EV_REPEAT  = 2'd2
   } evt_kind_type;

   typedef struct packed {
      cmd_type                command;
      logic [DELAY_W-1:0]     elapsed_ms;
      logic                   repeat_strobe;
      logic [KEY_W-1:0]       key_code;
      logic [NUM_BUTTONS-1:0] button_bits;
      logic [TIME_W-1:0]      event_time;
   } req_type;

   typedef struct packed {
      evt_kind_type      event_kind;
      logic [DIR_W-1:0]  direction_code;
      logic [TIME_W-1:0] time_ms;
      logic              last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [SLOTS-1:0]  mask;
      logic [DIR_W-1:0]  rel_dir;
      logic [DIR_W-1:0]  prs_dir;
      logic [DIR_W-1:0]  rep_dir;
      logic [TIME_W-1:0] time_ms;
   } desc_type;

   function automatic logic [DIR_W-1:0] qualify(logic [1:0] i, logic [NUM_BUTTONS-1:0] bits);
      logic [DIR_W-1:0] d;
      d = {1'b0, i, 1'b1};
      if (bits[2'(i - 2'd1)]) d = d - 4'd1;
      if (bits[2'(i + 2'd1)]) d = d + 4'd1;
      return d;
   endfunction

   function automatic logic [DIR_W-1:0] pressed_dir(logic [NUM_BUTTONS-1:0] bits);
      logic [DIR_W-1:0] d;
      d = '0;
      for (int k = 0; k < NUM_BUTTONS; k++) begin
         if (bits[k]) d = qualify(2'(k), bits);
      end
      return d;
   endfunction

   function automatic logic [DIR_W-1:0] key_dir(logic [NUM_BUTTONS-1:0] match,
                                                logic [NUM_BUTTONS-1:0] bits);
      logic [DIR_W-1:0] d;
      d = '0;
      for (int k = 0; k < NUM_BUTTONS; k++) begin
         if (match[k]) d = qualify(2'(k), bits);
      end
      return d;
   endfunction

endpackage

/* hdl/dpad_eight_way_direction_qualifier_core.sv */
// D-pad eight-way direction qualifier, top level. Folds four direction buttons into a
// direction code 0..8, debounces changes seen on ticks against a settle deadline and
// reports release, press and repeat events. An input word is taken by the front end
// whenever the descriptor queue (QDEPTH entries) has room; words that yield no events are
// not queued. The back end writes each queued item's one to three result words to the
// output register at one per cycle while it is empty or being popped. With both queue
// and output register empty, an accepted word is written into the queue and its first
// result then into the output register. The configuration port is always ready.
// Depends on dpq_pkg, dpq_front, dpq_queue and dpq_back.
module dpad_eight_way_direction_qualifier_core import dpq_pkg::*; #(
   parameter int QDEPTH = QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  req_type                req_data,
   output logic                   req_full,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic     accept;
   logic     desc_push;
   desc_type desc;
   desc_type head;
   logic     q_full, q_empty, head_pop;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;
   assign accept    = req_push && !q_full;

   dpq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .desc_push (desc_push),
      .desc      (desc)
   );

   dpq_queue #(.DEPTH(QDEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_data (desc),
      .pop       (head_pop),
      .head      (head),
      .full      (q_full),
      .empty     (q_empty)
   );

   dpq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (!q_empty),
      .head_pop   (head_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_data   (rsp_data)
   );

endmodule

/* hdl/dpq_front.sv */
// Front end: configuration registers, direction state and settle timer.
// Classifies each accepted word into a descriptor of up to three events. Uses dpq_pkg.
module dpq_front import dpq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  req_type                req_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                   desc_push,
   output desc_type               desc
);

   logic [DELAY_W-1:0] settle_ff;
   logic [KEY_W-1:0]   code_ff [NUM_BUTTONS];
   logic [DIR_W-1:0]   cur_dir_ff, cur_dir_in;
   logic [TIME_W-1:0]  run_time_ff, run_time_in;
   logic               pending_ff, pending_in;
   logic [TIME_W-1:0]  deadline_ff, deadline_in;

   logic [NUM_BUTTONS-1:0] match;
   logic [DIR_W-1:0]       btn_dir;
   logic [DIR_W-1:0]       kdir;
   logic [TIME_W-1:0]      rt_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_RESET;
         for (int k = 0; k < NUM_BUTTONS; k++) code_ff[k] <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SETTLE: settle_ff  <= csr_wdata[DELAY_W-1:0];
            CSR_CODE0:  code_ff[0] <= csr_wdata;
            CSR_CODE1:  code_ff[1] <= csr_wdata;
            CSR_CODE2:  code_ff[2] <= csr_wdata;
            CSR_CODE3:  code_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_BUTTONS; k++) match[k] = (req_data.key_code == code_ff[k]);
   end

   assign btn_dir = pressed_dir(req_data.button_bits);
   assign kdir    = key_dir(match, req_data.button_bits);
   assign rt_sum  = run_time_ff + TIME_W'(req_data.elapsed_ms);

   always_comb begin
      cur_dir_in   = cur_dir_ff;
      run_time_in  = run_time_ff;
      pending_in   = pending_ff;
      deadline_in  = deadline_ff;
      desc         = '0;
      desc.rel_dir = cur_dir_ff;
      desc.time_ms = req_data.event_time;
      unique case (req_data.command)
         CMD_TICK: begin
            run_time_in  = rt_sum;
            desc.time_ms = rt_sum;
            if (pending_ff) begin
               if (deadline_ff <= rt_sum) begin
                  pending_in              = 1'b0;
                  cur_dir_in              = btn_dir;
                  desc.prs_dir            = btn_dir;
                  desc.mask[SLOT_REL]     = (cur_dir_ff != '0);
                  desc.mask[SLOT_PRS]     = (btn_dir != '0);
               end
            end else if (cur_dir_ff != btn_dir) begin
               pending_in  = 1'b1;
               deadline_in = rt_sum + TIME_W'(settle_ff);
            end
            desc.rep_dir        = cur_dir_in;
            desc.mask[SLOT_REP] = req_data.repeat_strobe && (cur_dir_in != '0);
         end
         CMD_PRESS: begin
            desc.prs_dir = kdir;
            if (kdir != '0 && kdir != cur_dir_ff) begin
               desc.mask[SLOT_REL] = 1'b1;
               desc.mask[SLOT_PRS] = 1'b1;
               cur_dir_in          = kdir;
            end
         end
         CMD_RELEASE: begin
            desc.prs_dir = btn_dir;
            if (btn_dir != cur_dir_ff) begin
               desc.mask[SLOT_REL] = (cur_dir_ff != '0);
               desc.mask[SLOT_PRS] = (btn_dir != '0);
               cur_dir_in          = btn_dir;
            end
         end
         CMD_REPEAT: begin
            desc.rep_dir        = cur_dir_ff;
            desc.mask[SLOT_REP] = (kdir == cur_dir_ff);
         end
         default: ;
      endcase
   end

   assign desc_push = accept && (desc.mask != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_dir_ff  <= '0;
         run_time_ff <= '0;
         pending_ff  <= 1'b0;
         deadline_ff <= '0;
      end else if (accept) begin
         cur_dir_ff  <= cur_dir_in;
         run_time_ff <= run_time_in;
         pending_ff  <= pending_in;
         deadline_ff <= deadline_in;
      end
   end

endmodule

/* hdl/dpq_queue.sv */
// Descriptor queue between front and back ends.
// Register-array FIFO of desc_type entries. Uses dpq_pkg.
module dpq_queue import dpq_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_data,
   input  logic     pop,
   output desc_type head,
   output logic     full,
   output logic     empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   desc_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

/* hdl/dpq_back.sv */
// Back end: expands the head descriptor into result words in the output register,
// one per cycle while that register is empty or being popped. Uses dpq_pkg.
module dpq_back import dpq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  desc_type head,
   input  logic     head_valid,
   output logic     head_pop,
   input  logic     rsp_pop,
   output logic     rsp_empty,
   output rsp_type  rsp_data
);

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic [SLOTS-1:0] done_ff, done_in;
   logic [SLOTS-1:0] remaining, sel, rest;
   logic             emit, last;

   assign remaining = head.mask & ~done_ff;
   assign emit      = head_valid && (!rsp_valid_ff || rsp_pop);

   always_comb begin
      sel = '0;
      if (remaining[SLOT_REL])      sel[SLOT_REL] = 1'b1;
      else if (remaining[SLOT_PRS]) sel[SLOT_PRS] = 1'b1;
      else                          sel[SLOT_REP] = 1'b1;
   end

   assign rest     = remaining & ~sel;
   assign last     = (rest == '0);
   assign head_pop = emit && last;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_data_in  = rsp_data_ff;
      done_in      = done_ff;
      if (emit) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.time_ms  = head.time_ms;
         rsp_data_in.last_of_run = last;
         if (sel[SLOT_REL]) begin
            rsp_data_in.event_kind     = EV_RELEASE;
            rsp_data_in.direction_code = head.rel_dir;
         end else if (sel[SLOT_PRS]) begin
            rsp_data_in.event_kind     = EV_PRESS;
            rsp_data_in.direction_code = head.prs_dir;
         end else begin
            rsp_data_in.event_kind     = EV_REPEAT;
            rsp_data_in.direction_code = head.rep_dir;
         end
         done_in = last ? '0 : (done_ff | sel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         done_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_head_not_blank: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (head.mask != '0))
      else $error("queued descriptor carries no events");

   a_done_within_mask: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> ((done_ff & ~head.mask) == '0))
      else $error("done slots outside descriptor mask");

   a_done_needs_head: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> (done_ff == '0))
      else $error("done slots held with no descriptor");

   a_pop_clears_done: assert property (@(posedge clock) disable iff (reset)
      head_pop |=> (done_ff == '0) && rsp_data.last_of_run)
      else $error("descriptor retired without closing its run");

endmodule
